// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers included by fire_heat_field_update_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- hw/rtl/fhf_pkg.sv -----
package fhf_pkg;

    // Width of one heat cell and of the heat field on the ports.
    localparam int HEAT_W = 6;

    // Smallest grid dimension a register write can select.
    localparam int MIN_DIM = 16;

    // Last palette entry; hotter cells use this color.
    localparam int PAL_LAST = 36;

    // Item kinds.
    localparam logic [1:0] KIND_PROP = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_INIT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    // One result as handed from the sequencer to the output stage.
    typedef struct packed {
        logic              acc;
        logic [HEAT_W-1:0] heat;
        logic              colour;
    } t_result;

    // Fire palette, black through red and yellow to white, as {r, g, b}.
    // Indexes above the last entry saturate to white.
    function automatic logic [23:0] pal_rgb(input logic [HEAT_W-1:0] h);
        logic [23:0] c;
        case (h)
            6'd0:    c = {8'd7,   8'd7,   8'd7};
            6'd1:    c = {8'd31,  8'd7,   8'd7};
            6'd2:    c = {8'd47,  8'd15,  8'd7};
            6'd3:    c = {8'd71,  8'd15,  8'd7};
            6'd4:    c = {8'd87,  8'd23,  8'd7};
            6'd5:    c = {8'd103, 8'd31,  8'd7};
            6'd6:    c = {8'd119, 8'd31,  8'd7};
            6'd7:    c = {8'd143, 8'd39,  8'd7};
            6'd8:    c = {8'd159, 8'd47,  8'd7};
            6'd9:    c = {8'd175, 8'd63,  8'd7};
            6'd10:   c = {8'd191, 8'd71,  8'd7};
            6'd11:   c = {8'd199, 8'd71,  8'd7};
            6'd12:   c = {8'd223, 8'd79,  8'd7};
            6'd13:   c = {8'd223, 8'd87,  8'd7};
            6'd14:   c = {8'd223, 8'd87,  8'd7};
            6'd15:   c = {8'd215, 8'd95,  8'd7};
            6'd16:   c = {8'd215, 8'd95,  8'd7};
            6'd17:   c = {8'd215, 8'd103, 8'd15};
            6'd18:   c = {8'd207, 8'd111, 8'd15};
            6'd19:   c = {8'd207, 8'd119, 8'd15};
            6'd20:   c = {8'd207, 8'd127, 8'd15};
            6'd21:   c = {8'd207, 8'd135, 8'd23};
            6'd22:   c = {8'd199, 8'd135, 8'd23};
            6'd23:   c = {8'd199, 8'd143, 8'd23};
            6'd24:   c = {8'd199, 8'd151, 8'd31};
            6'd25:   c = {8'd191, 8'd159, 8'd31};
            6'd26:   c = {8'd191, 8'd159, 8'd31};
            6'd27:   c = {8'd191, 8'd167, 8'd39};
            6'd28:   c = {8'd191, 8'd167, 8'd39};
            6'd29:   c = {8'd191, 8'd175, 8'd47};
            6'd30:   c = {8'd183, 8'd175, 8'd47};
            6'd31:   c = {8'd183, 8'd183, 8'd47};
            6'd32:   c = {8'd183, 8'd183, 8'd55};
            6'd33:   c = {8'd207, 8'd207, 8'd111};
            6'd34:   c = {8'd223, 8'd223, 8'd159};
            6'd35:   c = {8'd239, 8'd239, 8'd199};
            default: c = {8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/fhf_grid_mem.sv -----
// Single-port heat grid store: one read or one write per cycle,
// read data registered and held until the next read.
module fhf_grid_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_addr,
    input  logic [fhf_pkg::HEAT_W-1:0] i_wdata,
    output logic [fhf_pkg::HEAT_W-1:0] o_rdata
);

    logic [fhf_pkg::HEAT_W-1:0] r_mem [DEPTH];
    logic [fhf_pkg::HEAT_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_en && !i_we) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fhf_out_stage.sv -----
// Output register: holds one result, decodes its palette color and
// takes a new result in the same cycle the held one is transferred.
module fhf_out_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  fhf_pkg::t_result           i_res,
    output logic                       o_free,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_accepted,
    output logic [fhf_pkg::HEAT_W-1:0] o_heat_value,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic                       o_lit
);

    logic             r_valid;
    fhf_pkg::t_result r_res;
    logic [23:0]      rgb;

    assign o_free = !r_valid || i_out_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    // Palette lookup on the held heat; uncolored results read as zero.
    always_comb begin
        rgb = r_res.colour ? fhf_pkg::pal_rgb(r_res.heat) : 24'd0;
    end

    assign o_out_valid  = r_valid;
    assign o_accepted   = r_res.acc;
    assign o_heat_value = r_res.heat;
    assign o_red        = rgb[23:16];
    assign o_green      = rgb[15:8];
    assign o_blue       = rgb[7:0];
    assign o_lit        = r_res.colour && (r_res.heat != '0);

endmodule

// ----- hw/rtl/fire_heat_field_update_unit.sv -----
// Channel | Direction | Transfer when          | Payload
// in      | to block  | i_in_valid & o_in_ready | kind, col, row, cool, drift
// out     | from block| o_out_valid & i_out_ready | accepted, heat_value, rgb, lit
// cfg     | to block  | i_cfg_valid & o_cfg_ready | cfg_index, cfg_data
//
// An item inside the grid is read from the grid memory in its transfer cycle;
// in S_CALC a propagate item writes its cell back one row up and the result
// loads the output register once it is free. No new item is taken meanwhile.
// After reset, an init item, or a register write that changes the grid
// size, a clearing pass rewrites all MAX_COLS columns of the grid_height rows
// in use; o_in_ready stays low during it, register writes are still taken.
// A result waits in the sequencer while the output register is full and
// not being transferred.
`include "assert_macros.svh"

module fire_heat_field_update_unit #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256,
    parameter int TOP_HEAT = 36
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input items
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_kind,
    input  logic [7:0]                 i_col,
    input  logic [7:0]                 i_row,
    input  logic                       i_cool,
    input  logic signed [1:0]          i_drift,
    // Results
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_accepted,
    output logic [fhf_pkg::HEAT_W-1:0] o_heat_value,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic                       o_lit,
    // Register writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [8:0]                 i_cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DWC   = $clog2(MAX_COLS + 1);
    localparam int DWR   = $clog2(MAX_ROWS + 1);
    localparam int DWM   = (DWC > DWR) ? DWC : DWR;
    localparam int EW    = (DWM > 9) ? DWM : 9;
    localparam int RST_W = (225 < fhf_pkg::MIN_DIM) ? fhf_pkg::MIN_DIM :
                           ((225 > MAX_COLS) ? MAX_COLS : 225);
    localparam int RST_H = (140 < fhf_pkg::MIN_DIM) ? fhf_pkg::MIN_DIM :
                           ((140 > MAX_ROWS) ? MAX_ROWS : 140);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic                       r_state;
    logic [EW-1:0]              r_w;
    logic [EW-1:0]              r_h;
    logic                       r_clearing;
    logic [RW-1:0]              r_clr_row;
    logic [CW-1:0]              r_clr_col;

    logic [1:0]                 r_kind;
    logic                       r_inside;
    logic                       r_act;
    logic [7:0]                 r_col;
    logic [7:0]                 r_row;
    logic                       r_cool;
    logic [1:0]                 r_drift;

    logic                       accept;
    logic                       in_inside;
    logic [EW-1:0]              cfg_v;
    logic [EW-1:0]              n_w;
    logic [EW-1:0]              n_h;
    logic                       cfg_change;
    logic                       clr_last;
    logic [AW-1:0]              clr_addr;
    logic [fhf_pkg::HEAT_W-1:0] clr_val;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [EW-1:0]              dst;
    logic [EW-1:0]              colp1;
    logic [fhf_pkg::HEAT_W-1:0] rdata;
    logic [fhf_pkg::HEAT_W-1:0] prop_v;
    fhf_pkg::t_result           res;
    logic                       out_free;
    logic                       push;

    logic                       mem_en;
    logic                       mem_we;
    logic [AW-1:0]              mem_addr;
    logic [fhf_pkg::HEAT_W-1:0] mem_wdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && !r_clearing;
    assign accept      = i_in_valid && o_in_ready;
    assign in_inside   = (EW'(i_col) < r_w) && (EW'(i_row) < r_h);

    // Saturate a register write to the legal grid size and detect a change.
    always_comb begin
        cfg_v = EW'(i_cfg_data);
        n_w   = r_w;
        n_h   = r_h;
        if (i_cfg_valid && (i_cfg_index == fhf_pkg::CFG_WIDTH)) begin
            if (cfg_v < EW'(fhf_pkg::MIN_DIM)) begin
                n_w = EW'(fhf_pkg::MIN_DIM);
            end else if (cfg_v > EW'(MAX_COLS)) begin
                n_w = EW'(MAX_COLS);
            end else begin
                n_w = cfg_v;
            end
        end
        if (i_cfg_valid && (i_cfg_index == fhf_pkg::CFG_HEIGHT)) begin
            if (cfg_v < EW'(fhf_pkg::MIN_DIM)) begin
                n_h = EW'(fhf_pkg::MIN_DIM);
            end else if (cfg_v > EW'(MAX_ROWS)) begin
                n_h = EW'(MAX_ROWS);
            end else begin
                n_h = cfg_v;
            end
        end
        cfg_change = (n_w != r_w) || (n_h != r_h);
    end

    // Grid size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= EW'(RST_W);
            r_h <= EW'(RST_H);
        end else begin
            r_w <= n_w;
            r_h <= n_h;
        end
    end

    // Clearing pass: zero every row in use, seed the bottom row's columns inside the grid width.
    assign clr_last = (EW'(r_clr_row) == (r_h - EW'(1)))
                   && (r_clr_col == CW'(MAX_COLS - 1));
    assign clr_addr = AW'(AW'(r_clr_row) * AW'(MAX_COLS)) + AW'(r_clr_col);
    assign clr_val  = ((EW'(r_clr_row) == (r_h - EW'(1))) && (EW'(r_clr_col) < r_w))
                    ? fhf_pkg::HEAT_W'(TOP_HEAT) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
            r_clr_col  <= '0;
        end else if (cfg_change || (push && (r_kind == fhf_pkg::KIND_INIT))) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
            r_clr_col  <= '0;
        end else if (r_clearing) begin
            if (clr_last) begin
                r_clearing <= 1'b0;
            end else if (r_clr_col == CW'(MAX_COLS - 1)) begin
                r_clr_col <= '0;
                r_clr_row <= r_clr_row + RW'(1);
            end else begin
                r_clr_col <= r_clr_col + CW'(1);
            end
        end
    end

    // Item registers, loaded on the input transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_kind;
            r_inside <= in_inside;
            r_act    <= in_inside && (i_row != 8'd0);
            r_col    <= i_col;
            r_row    <= i_row;
            r_cool   <= i_cool;
            r_drift  <= i_drift;
        end
    end

    // Sequencer: read on transfer, finish in S_CALC once the output register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Destination column one row up, clamped to the grid.
    always_comb begin
        colp1 = EW'(r_col) + EW'(1);
        if (r_drift == 2'b01) begin
            dst = (colp1 >= r_w) ? (r_w - EW'(1)) : colp1;
        end else if (r_drift[1]) begin
            dst = (r_col == 8'd0) ? '0 : (EW'(r_col) - EW'(1));
        end else begin
            dst = EW'(r_col);
        end
    end

    assign rd_addr = AW'(AW'(i_row) * AW'(MAX_COLS)) + AW'(i_col);
    assign wr_addr = AW'(AW'(r_row - 8'd1) * AW'(MAX_COLS)) + AW'(dst);
    assign prop_v  = (rdata > fhf_pkg::HEAT_W'(r_cool))
                   ? (rdata - fhf_pkg::HEAT_W'(r_cool)) : '0;

    // Result of the item in flight.
    always_comb begin
        res = '0;
        case (r_kind)
            fhf_pkg::KIND_PROP: begin
                if (r_act) begin
                    res.acc    = 1'b1;
                    res.heat   = prop_v;
                    res.colour = 1'b1;
                end
            end
            fhf_pkg::KIND_READ: begin
                if (r_inside) begin
                    res.acc    = 1'b1;
                    res.heat   = rdata;
                    res.colour = 1'b1;
                end
            end
            fhf_pkg::KIND_INIT: begin
                res.acc = 1'b1;
            end
            default: res = '0;
        endcase
    end

    assign push = (r_state == S_CALC) && out_free;

    // Memory port: clearing pass, then item read, then write-back.
    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        if (r_clearing) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_addr;
            mem_wdata = clr_val;
        end else if (accept && in_inside) begin
            mem_en   = 1'b1;
            mem_addr = rd_addr;
        end else if (push && r_act && (r_kind == fhf_pkg::KIND_PROP)) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = wr_addr;
            mem_wdata = prop_v;
        end
    end

    fhf_grid_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (rdata)
    );

    fhf_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_res        (res),
        .o_free       (out_free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_accepted   (o_accepted),
        .o_heat_value (o_heat_value),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_lit        (o_lit)
    );

    // Checks on the sequencer and the memory port.
    `ASSERT_NEVER(a_no_accept_in_clear, i_clk, i_rst_n, o_in_ready && r_clearing, "item taken during clearing pass")
    `ASSERT_AT(a_accept_to_calc, i_clk, i_rst_n, accept |=> (r_state == S_CALC), "transfer did not start an item")
    `ASSERT_NEVER(a_push_outside_calc, i_clk, i_rst_n, push && (r_state != S_CALC), "result loaded with no item in flight")
    `ASSERT_NEVER(a_stray_write, i_clk, i_rst_n, mem_we && !r_clearing && !(push && r_act), "grid written outside clearing or write-back")

endmodule
